### hdl/sfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared formats, register indexes and types of the sample converter.
// ----------------------------------------------------------------------------
package sfd_pkg;

   typedef enum logic [3:0] {
      FMT_S4 = 4'd0,
      FMT_I4 = 4'd1,
      FMT_S2 = 4'd2,
      FMT_I2 = 4'd3,
      FMT_S3 = 4'd4,
      FMT_I3 = 4'd5,
      FMT_T4 = 4'd6,
      FMT_F4 = 4'd7,
      FMT_T8 = 4'd8,
      FMT_F8 = 4'd9
   } format_type;

   localparam logic [0:0] REG_FORMAT = 1'b0;
   localparam logic [0:0] REG_COUNT  = 1'b1;

   typedef enum logic [1:0] {
      KIND_INT  = 2'd0,
      KIND_FLT  = 2'd1,
      KIND_DBL  = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [5:0] width;
   } conv_ctl_type;

endpackage

### hdl/sfd_convert.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_convert
// Converts an assembled sample word to a binary64 bit pattern.
// ----------------------------------------------------------------------------
module sfd_convert
   import sfd_pkg::*;
(
   input  conv_ctl_type ctl,
   input  logic [63:0]  raw,
   output logic [63:0]  bits
);

   logic [31:0] ival;
   logic        ineg;
   logic [31:0] mag;
   logic [4:0]  ip;
   logic [63:0] ishift;
   logic [63:0] ibits;
   logic [7:0]  fe;
   logic [22:0] fm;
   logic [4:0]  fp;
   logic [63:0] fshift;
   logic [63:0] fbits;
   logic [51:0] nan_mant;

   always_comb begin
      case (ctl.width)
         6'd16:   ival = {{16{raw[15]}}, raw[15:0]};
         6'd24:   ival = {{8{raw[23]}}, raw[23:0]};
         default: ival = raw[31:0];
      endcase
      ineg = ival[31];
      mag = ineg ? (~ival + 32'd1) : ival;
      ip = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (mag[i]) ip = 5'(i);
      end
      ishift = {32'd0, mag} << (6'd52 - {1'b0, ip});
      if (mag == 32'd0) ibits = 64'd0;
      else ibits = {ineg, 11'(11'd1023 + {6'd0, ip}), ishift[51:0]};
   end

   always_comb begin
      fe = raw[30:23];
      fm = raw[22:0];
      fp = 5'd0;
      for (int i = 0; i < 23; i++) begin
         if (fm[i]) fp = 5'(i);
      end
      fshift = {41'd0, fm} << (6'd52 - {1'b0, fp});
      nan_mant = {fm, 29'd0};
      if (fm != 23'd0) nan_mant[51] = 1'b1;
      if (fe == 8'hff) begin
         fbits = {raw[31], 11'h7ff, nan_mant};
      end else if (fe == 8'd0) begin
         if (fm == 23'd0) fbits = {raw[31], 63'd0};
         else fbits = {raw[31], 11'(11'd874 + {6'd0, fp}), fshift[51:0]};
      end else begin
         fbits = {raw[31], 11'({3'd0, fe} + 11'd896), fm, 29'd0};
      end
   end

   always_comb begin
      case (ctl.kind)
         KIND_INT: bits = ibits;
         KIND_FLT: bits = fbits;
         default:  bits = raw;
      endcase
   end

endmodule

### hdl/sample_format_to_double_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_format_to_double_core
// Byte-serial sample assembler and binary64 converter.
// ----------------------------------------------------------------------------
// One byte word is taken per clock while the output stage has room. When a
// byte completes a sample (2, 3, 4 or 8 bytes by format) the converted double
// is registered into a two-entry output stage, which keeps the req side open
// while a result waits. Formats above 9 drop every byte. Any csr write restarts
// the sample and block count. rsp_tuser is high on the last sample of a block.
module sample_format_to_double_core
   import sfd_pkg::*;
#(
   parameter int COUNT_BITS = 16
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // double_bits
   output logic        rsp_tuser,   // last_sample
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   logic [3:0]            fmt_ff;
   logic [COUNT_BITS-1:0] cnt_ff;
   logic [63:0]           asm_ff, asm_in;
   logic [2:0]            pos_ff, pos_in;
   logic [COUNT_BITS-1:0] done_ff, done_in;
   logic [COUNT_BITS-1:0] next_done;
   logic [3:0]            size;
   logic                  big, known, take, done_sample, last;
   conv_ctl_type          ctl;
   logic [63:0]           conv;
   logic [63:0]           asm_new;
   logic [64:0]           q_ff [2];
   logic [1:0]            qn_ff;
   logic                  push, pop;

   always_comb begin
      known = 1'b1;
      ctl   = '{kind: KIND_INT, width: 6'd32};
      case (format_type'(fmt_ff))
         FMT_S4, FMT_I4: size = 4'd4;
         FMT_S2, FMT_I2: begin size = 4'd2; ctl.width = 6'd16; end
         FMT_S3, FMT_I3: begin size = 4'd3; ctl.width = 6'd24; end
         FMT_T4, FMT_F4: begin size = 4'd4; ctl.kind = KIND_FLT; end
         FMT_T8, FMT_F8: begin size = 4'd8; ctl.kind = KIND_DBL; end
         default: begin size = 4'd8; known = 1'b0; end
      endcase
      big = ~fmt_ff[0];
   end

   assign req_tready = (qn_ff != 2'd2);
   assign take = req_tvalid & req_tready & known;
   assign asm_new = big ? {asm_ff[55:0], req_tdata}
                        : asm_ff | ({56'd0, req_tdata} << {pos_ff, 3'b000});
   assign done_sample = ({1'b0, pos_ff} + 4'd1) == size;
   assign next_done = done_ff + COUNT_BITS'(1);
   assign last = next_done == cnt_ff;

   sfd_convert u_convert (.ctl(ctl), .raw(asm_new), .bits(conv));

   always_comb begin
      asm_in  = asm_ff;
      pos_in  = pos_ff;
      done_in = done_ff;
      if (take) begin
         if (done_sample) begin
            asm_in  = 64'd0;
            pos_in  = 3'd0;
            done_in = last ? '0 : next_done;
         end else begin
            asm_in = asm_new;
            pos_in = pos_ff + 3'd1;
         end
      end
      if (csr_we) begin
         asm_in  = 64'd0;
         pos_in  = 3'd0;
         done_in = '0;
      end
   end

   assign push = take & done_sample;
   assign pop  = rsp_tvalid & rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff  <= 4'd0;
         cnt_ff  <= COUNT_BITS'(1);
         asm_ff  <= 64'd0;
         pos_ff  <= 3'd0;
         done_ff <= '0;
         qn_ff   <= 2'd0;
      end else begin
         asm_ff  <= asm_in;
         pos_ff  <= pos_in;
         done_ff <= done_in;
         if (csr_we) begin
            if (csr_index == REG_FORMAT) fmt_ff <= csr_wdata[3:0];
            if (csr_index == REG_COUNT) cnt_ff <= COUNT_BITS'(csr_wdata);
         end
         qn_ff <= qn_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (pop) q_ff[0] <= q_ff[1];
      if (push) begin
         if (pop) begin
            if (qn_ff == 2'd1) q_ff[0] <= {last, conv};
            else q_ff[1] <= {last, conv};
         end else begin
            if (qn_ff == 2'd0) q_ff[0] <= {last, conv};
            else q_ff[1] <= {last, conv};
         end
      end
   end

   assign rsp_tvalid = (qn_ff != 2'd0);
   assign rsp_tdata  = q_ff[0][63:0];
   assign rsp_tuser  = q_ff[0][64];

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      qn_ff == 2'd2 |-> !push) else $error("output queue overflow");
   a_push_valid: assert property (@(posedge clock) disable iff (reset)
      push |=> rsp_tvalid) else $error("result lost");
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      known |-> ({1'b0, pos_ff} < size)) else $error("byte position out of range");
   a_csr_clear: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> (pos_ff == 3'd0 && done_ff == '0)) else $error("csr did not clear");
`endif

endmodule
